>>> rtl/core/assert_macros.svh
// Assertion macros for the RTL of the user key check block.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge outside reset.
`define PRKC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Condition a at one edge implies b at the next edge.
`define PRKC_NEXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> rtl/core/prkc_pkg.sv
// Package of the user key check block: op codes, command struct, tables.
// Used by prkc_ctrl, prkc_dp and pdf_rc4_user_key_check.
package prkc_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int FILE_ID_BYTES = 16;
    localparam int TAG_BITS      = 16;
    localparam int LAST_PASS     = 19;
    localparam int MIN_KEY_BYTES = 5;
    localparam logic [2:0] REV_SINGLE = 3'd2;

    localparam logic [2:0] OP_IDLE = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;
    localparam logic [2:0] OP_MD5  = 3'd2;
    localparam logic [2:0] OP_FIN  = 3'd3;
    localparam logic [2:0] OP_INIT = 3'd4;
    localparam logic [2:0] OP_KSA  = 3'd5;
    localparam logic [2:0] OP_PRGA = 3'd6;
    localparam logic [2:0] OP_OUT  = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] sub;
        logic [8:0] cnt;
        logic [4:0] pass;
    } t_cmd;

    localparam logic [255:0] PAD_BYTES = {
        64'h7A69536_4FEA90C2F, 64'h803E68D0B6002E2E,
        64'h0801FAFF564E0064, 64'h418A754E5E4EBF28};

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;

    function automatic logic [4:0] md5_s(input logic [3:0] idx);
        logic [4:0] s;
        case (idx)
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/core/pdf_rc4_user_key_check.sv
// Top level of the PDF user key check: stream ports, register file, controller and datapath.
// Depends on prkc_pkg, prkc_ctrl and prkc_dp.
//
// Usage: each beat on the s_axis side is one candidate RC4 file key with its tag;
// the block answers with exactly one beat on the m_axis side saying whether the
// key reproduces the stored user check value, plus first-hit and batch flags.
// s_axis_tuser is chunk_start, s_axis_tlast marks the last key of a batch, and
// m_axis_tlast echoes it. The user must write registers over the APB port only while idle
// (the block does not enforce this). One key is worked on at a time: s_axis_tready is high
// only when idle. Work per key runs through the single-port 256-entry state memory:
//   revision 2:     fill, key schedule and output.
//   other revision: 64 MD5 rounds, then 20 passes of fill, key schedule and output.
// A finished result waits in the output register while m_axis_tready is low;
// the next key is accepted meanwhile and its result is held until that slot frees.
// Synchronous reset clears the controller, the result valid and the hit latches
// and restores register defaults (revision 3, key length 16, others zero).
module pdf_rc4_user_key_check (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [143:0]  s_axis_tdata,  // key_low[63:0], key_high[127:64], key_tag[143:128]
    input  logic          s_axis_tuser,  // chunk_start
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [23:0]   m_axis_tdata,  // match[0], first_hit[1], result_tag[17:2],
                                          // batch_hit[18], zero[23:19]
    output logic          m_axis_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import prkc_pkg::*;

    localparam logic [2:0] REG_REV   = 3'd0;
    localparam logic [2:0] REG_KLEN  = 3'd1;
    localparam logic [2:0] REG_IDLO  = 3'd2;
    localparam logic [2:0] REG_IDHI  = 3'd3;
    localparam logic [2:0] REG_U0    = 3'd4;
    localparam logic [2:0] REG_U1    = 3'd5;
    localparam logic [2:0] REG_U2    = 3'd6;
    localparam logic [2:0] REG_U3    = 3'd7;

    logic [2:0]  r_revision;
    logic [4:0]  r_key_len;
    logic [63:0] r_id_lo, r_id_hi, r_u0, r_u1, r_u2, r_u3;
    logic [4:0]  key_len;
    logic        rev_single, wr;
    t_cmd        cmd;
    logic        match, first_hit, batch_hit;
    logic [15:0] tag;

    assign pready     = 1'b1;
    assign wr         = psel && penable && pwrite;
    assign rev_single = (r_revision == REV_SINGLE);
    assign key_len    = (r_key_len < 5'(MIN_KEY_BYTES)) ? 5'(MIN_KEY_BYTES) :
                        (r_key_len > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES) : r_key_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_revision <= 3'd3;
            r_key_len  <= 5'd16;
            r_id_lo <= '0; r_id_hi <= '0;
            r_u0 <= '0; r_u1 <= '0; r_u2 <= '0; r_u3 <= '0;
        end else if (wr) begin
            case (paddr[5:3])
                REG_REV:  r_revision <= pwdata[2:0];
                REG_KLEN: r_key_len  <= pwdata[4:0];
                REG_IDLO: r_id_lo    <= pwdata;
                REG_IDHI: r_id_hi    <= pwdata;
                REG_U0:   r_u0       <= pwdata;
                REG_U1:   r_u1       <= pwdata;
                REG_U2:   r_u2       <= pwdata;
                REG_U3:   r_u3       <= pwdata;
                default:  r_u3       <= r_u3;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_REV:  prdata = {61'd0, r_revision};
            REG_KLEN: prdata = {59'd0, r_key_len};
            REG_IDLO: prdata = r_id_lo;
            REG_IDHI: prdata = r_id_hi;
            REG_U0:   prdata = r_u0;
            REG_U1:   prdata = r_u1;
            REG_U2:   prdata = r_u2;
            default:  prdata = r_u3;
        endcase
    end

    prkc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_rev_single (rev_single),
        .o_cmd        (cmd)
    );

    prkc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_key         (s_axis_tdata[127:0]),
        .i_tag         (s_axis_tdata[143:128]),
        .i_chunk_start (s_axis_tuser),
        .i_batch_last  (s_axis_tlast),
        .i_rev_single  (rev_single),
        .i_key_len     (key_len),
        .i_file_id     ({r_id_hi, r_id_lo}),
        .i_u_value     ({r_u3, r_u2, r_u1, r_u0}),
        .o_match       (match),
        .o_first_hit   (first_hit),
        .o_tag         (tag),
        .o_batch_end   (m_axis_tlast),
        .o_batch_hit   (batch_hit)
    );

    assign m_axis_tdata = {5'd0, batch_hit, tag, first_hit, match};
endmodule

>>> rtl/core/prkc_ctrl.sv
// Sequencer of the user key check: MD5 rounds, RC4 schedule passes, result hand-off.
// Depends on prkc_pkg and assert_macros.svh; drives prkc_dp by command struct.
`include "assert_macros.svh"
module prkc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  logic           i_rev_single,
    output prkc_pkg::t_cmd o_cmd
);
    import prkc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MD5  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_INIT = 3'd3;
    localparam logic [2:0] S_KSA  = 3'd4;
    localparam logic [2:0] S_PRGA = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [8:0] r_cnt, n_cnt;
    logic [2:0] r_sub, n_sub;
    logic [4:0] r_pass, n_pass;
    logic       r_ovalid, n_ovalid;
    logic [8:0] last_k;
    logic       accept, load_out;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign load_out    = (r_state == S_OUT) && (!r_ovalid || i_out_ready);
    assign last_k      = i_rev_single ? 9'd31 : 9'd15;

    always_comb begin
        o_cmd.sub  = r_sub;
        o_cmd.cnt  = r_cnt;
        o_cmd.pass = r_pass;
        case (r_state)
            S_IDLE:  o_cmd.op = accept ? OP_LOAD : OP_IDLE;
            S_MD5:   o_cmd.op = OP_MD5;
            S_FIN:   o_cmd.op = OP_FIN;
            S_INIT:  o_cmd.op = OP_INIT;
            S_KSA:   o_cmd.op = OP_KSA;
            S_PRGA:  o_cmd.op = OP_PRGA;
            S_OUT:   o_cmd.op = load_out ? OP_OUT : OP_IDLE;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sub    = r_sub;
        n_pass   = r_pass;
        n_ovalid = r_ovalid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_rev_single ? S_INIT : S_MD5;
                    n_cnt   = '0;
                    n_sub   = '0;
                    n_pass  = '0;
                end
            end
            S_MD5: begin
                n_cnt = r_cnt + 9'd1;
                if (r_cnt == 9'd63) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_INIT;
                n_cnt   = '0;
            end
            S_INIT: begin
                n_cnt = r_cnt + 9'd1;
                if (r_cnt == 9'd255) begin
                    n_state = S_KSA;
                    n_cnt   = '0;
                    n_sub   = '0;
                end
            end
            S_KSA: begin
                n_sub = r_sub + 3'd1;
                if (r_sub == 3'd3) begin
                    n_sub = '0;
                    n_cnt = r_cnt + 9'd1;
                    if (r_cnt == 9'd255) begin
                        n_state = S_PRGA;
                        n_cnt   = '0;
                    end
                end
            end
            S_PRGA: begin
                n_sub = r_sub + 3'd1;
                if (r_sub == 3'd5) begin
                    n_sub = '0;
                    n_cnt = r_cnt + 9'd1;
                    if (r_cnt == last_k) begin
                        n_cnt = '0;
                        if (i_rev_single || r_pass == 5'(LAST_PASS)) begin
                            n_state = S_OUT;
                        end else begin
                            n_pass  = r_pass + 5'd1;
                            n_state = S_INIT;
                        end
                    end
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_state  = S_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_sub    <= '0;
            r_pass   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_sub    <= n_sub;
            r_pass   <= n_pass;
            r_ovalid <= n_ovalid;
        end
    end

    `PRKC_ASSERT(a_pass_range, i_clk, i_rst_n, r_pass <= 5'(LAST_PASS))
    `PRKC_ASSERT(a_sub_range, i_clk, i_rst_n, r_sub <= 3'd5)
    `PRKC_NEXT(a_accept_busy, i_clk, i_rst_n, accept, r_state != S_IDLE)
    `PRKC_NEXT(a_out_sets_valid, i_clk, i_rst_n, load_out, r_ovalid)
endmodule

>>> rtl/core/prkc_dp.sv
// Datapath of the user key check: MD5 round unit, RC4 state memory, compare, latches.
// Depends on prkc_pkg; sequenced by prkc_ctrl through t_cmd.
module prkc_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  prkc_pkg::t_cmd i_cmd,
    input  logic [127:0]   i_key,
    input  logic [15:0]    i_tag,
    input  logic           i_chunk_start,
    input  logic           i_batch_last,
    input  logic           i_rev_single,
    input  logic [4:0]     i_key_len,
    input  logic [127:0]   i_file_id,
    input  logic [255:0]   i_u_value,
    output logic           o_match,
    output logic           o_first_hit,
    output logic [15:0]    o_tag,
    output logic           o_batch_end,
    output logic           o_batch_hit
);
    import prkc_pkg::*;

    logic [7:0]  r_sbox [256];
    logic [7:0]  r_rdata;
    logic [7:0]  mem_addr, mem_wdata;
    logic        mem_we;

    logic [7:0]  r_work [32];
    logic [127:0] r_key;
    logic [15:0] r_tag;
    logic        r_chunk_start, r_batch_last;
    logic [7:0]  r_j, r_si, r_sj;
    logic [3:0]  r_kpos;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic        r_chunk_found, r_batch_seen;

    logic [7:0]  key_byte, j_next, i_idx;
    logic [31:0] msg [16];
    logic [31:0] f, sum, rot;
    logic [3:0]  g;
    logic [4:0]  sh;
    logic [5:0]  rnd;
    logic [255:0] work_flat;
    logic [127:0] digest;
    logic        match, cf;

    assign rnd      = i_cmd.cnt[5:0];
    assign key_byte = r_key[{r_kpos, 3'b000} +: 8] ^ {3'b000, i_cmd.pass};
    assign i_idx    = (i_cmd.op == OP_PRGA) ? (i_cmd.cnt[7:0] + 8'd1) : i_cmd.cnt[7:0];
    assign j_next   = (i_cmd.op == OP_KSA) ? (r_j + r_rdata + key_byte) : (r_j + r_rdata);

    always_comb begin
        for (int w = 0; w < 8; w++) begin
            msg[w] = PAD_BYTES[32*w +: 32];
        end
        for (int w = 0; w < 4; w++) begin
            msg[8+w] = i_file_id[32*w +: 32];
        end
        msg[12] = 32'h00000080;
        msg[13] = '0;
        msg[14] = 32'((32 + FILE_ID_BYTES) * 8);
        msg[15] = '0;
    end

    always_comb begin
        case (rnd[5:4])
            2'd0: begin f = (r_b & r_c) | (~r_b & r_d); g = rnd[3:0]; end
            2'd1: begin f = (r_d & r_b) | (~r_d & r_c); g = rnd[3:0] * 4'd5 + 4'd1; end
            2'd2: begin f = r_b ^ r_c ^ r_d;            g = rnd[3:0] * 4'd3 + 4'd5; end
            default: begin f = r_c ^ (r_b | ~r_d);      g = rnd[3:0] * 4'd7; end
        endcase
        sh  = md5_s({rnd[5:4], rnd[1:0]});
        sum = r_a + f + md5_k(rnd) + msg[g];
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    assign digest = {r_d + IV3, r_c + IV2, r_b + IV1, r_a + IV0};

    always_comb begin
        mem_addr  = i_idx;
        mem_we    = 1'b0;
        mem_wdata = r_rdata;
        case (i_cmd.op)
            OP_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = i_cmd.cnt[7:0];
            end
            OP_KSA, OP_PRGA: begin
                case (i_cmd.sub)
                    3'd1: mem_addr = j_next;
                    3'd2: mem_we = 1'b1;
                    3'd3: begin
                        mem_addr  = r_j;
                        mem_we    = 1'b1;
                        mem_wdata = r_si;
                    end
                    3'd4: mem_addr = r_si + r_sj;
                    default: mem_addr = i_idx;
                endcase
            end
            default: mem_addr = i_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_sbox[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_sbox[mem_addr];
    end

    always_comb begin
        for (int b = 0; b < 32; b++) begin
            work_flat[8*b +: 8] = r_work[b];
        end
    end

    assign match = i_rev_single ? (work_flat == i_u_value)
                                : (work_flat[127:0] == i_u_value[127:0]);
    assign cf    = r_chunk_start ? 1'b0 : r_chunk_found;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_key         <= i_key;
                r_tag         <= i_tag;
                r_chunk_start <= i_chunk_start;
                r_batch_last  <= i_batch_last;
                r_a <= IV0; r_b <= IV1; r_c <= IV2; r_d <= IV3;
                for (int b = 0; b < 32; b++) begin
                    r_work[b] <= PAD_BYTES[8*b +: 8];
                end
            end
            OP_MD5: begin
                r_a <= r_d;
                r_d <= r_c;
                r_c <= r_b;
                r_b <= r_b + rot;
            end
            OP_FIN: begin
                for (int b = 0; b < 16; b++) begin
                    r_work[b]    <= digest[8*b +: 8];
                    r_work[16+b] <= '0;
                end
            end
            OP_INIT: begin
                r_j    <= '0;
                r_kpos <= '0;
            end
            OP_KSA, OP_PRGA: begin
                case (i_cmd.sub)
                    3'd0: begin
                        if (i_cmd.op == OP_PRGA && i_cmd.cnt == 9'd0) begin
                            r_j <= '0;
                        end
                    end
                    3'd1: begin
                        r_si <= r_rdata;
                        r_j  <= j_next;
                        if (i_cmd.op == OP_KSA) begin
                            r_kpos <= ({1'b0, r_kpos} == i_key_len - 5'd1) ? 4'd0
                                                                            : r_kpos + 4'd1;
                        end
                    end
                    3'd2: r_sj <= r_rdata;
                    3'd5: r_work[i_cmd.cnt[4:0]] <= r_work[i_cmd.cnt[4:0]] ^ r_rdata;
                    default: r_sj <= r_sj;
                endcase
            end
            OP_OUT: begin
                o_match     <= match;
                o_first_hit <= match && !cf;
                o_tag       <= r_tag;
                o_batch_end <= r_batch_last;
                o_batch_hit <= r_batch_last && (r_batch_seen || match);
            end
            default: r_j <= r_j;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_found <= 1'b0;
            r_batch_seen  <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_chunk_found <= cf || match;
            r_batch_seen  <= r_batch_last ? 1'b0 : (r_batch_seen || match);
        end
    end
endmodule
